@@ rtl/core/tsf_pkg.sv @@
// Shared types and constants for the top-k score threshold filter.
`default_nettype none

package tsf_pkg;

  // Scores are unsigned 16.16 fixed point held in 32 bits.
  localparam int SCORE_W = 32;

  // Held count and top_k register width.
  localparam int FILL_W = 7;

  // Configuration port widths.
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_ENABLE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_K         = 8'd1;

  // Heap operation codes.
  localparam logic OP_REPLACE = 1'b0;
  localparam logic OP_APPEND  = 1'b1;

  // One heap operation: for an append, count is the new slot; for a root
  // replacement, count is the number of held scores.
  typedef struct packed {
    logic               op;
    logic [FILL_W-1:0]  count;
    logic [SCORE_W-1:0] value;
  } heap_cmd_t;

endpackage

`default_nettype wire

@@ rtl/core/topk_score_threshold_filter.sv @@
// Top level: configuration, candidate decision, skip counter and result beat.
// A candidate that needs no heap update gives its result in the cycle after start;
// the next candidate may start in that cycle. An insertion sifts the min-heap one
// level per cycle through the heap memory, and busy holds off the next start until
// its result is given. Results cannot be stalled.
// Synchronous reset empties the heap, clears the skip count, sets filter on, k 10.
`default_nettype none

module topk_score_threshold_filter import tsf_pkg::*; #(
  parameter int HEAP_DEPTH = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [SCORE_W-1:0]    bound_score,
  input  wire logic [SCORE_W-1:0]    actual_score,
  input  wire logic                  clear_heap,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output logic                       done,
  output logic                       competitive,
  output logic                       inserted,
  output logic [SCORE_W-1:0]         current_threshold,
  output logic [FILL_W-1:0]          kept_count,
  output logic [SCORE_W-1:0]         skipped_total
);

  localparam logic [FILL_W-1:0] KCAP =
    (HEAP_DEPTH > 127) ? {FILL_W{1'b1}} : FILL_W'(HEAP_DEPTH);

  localparam logic T_IDLE = 1'b0;
  localparam logic T_WAIT = 1'b1;

  logic               state;
  logic               filter_enable;
  logic [FILL_W-1:0]  top_k;
  logic [FILL_W-1:0]  fill;
  logic [SCORE_W-1:0] skip;

  logic [FILL_W-1:0]  k_eff, fill_eff;
  logic               enabled, full, comp_now, accept, heap_go;
  logic [SCORE_W-1:0] thr_before, skip_next, root;
  heap_cmd_t          cmd;
  logic               hu_done;

  assign busy      = (state == T_WAIT);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // Candidate decision against the threshold held before this beat.
  always_comb begin
    k_eff      = (top_k > KCAP) ? KCAP : top_k;
    fill_eff   = clear_heap ? '0 : fill;
    enabled    = filter_enable && (k_eff != '0);
    full       = (fill_eff >= k_eff);
    thr_before = full ? root : '0;
    comp_now   = !enabled || (bound_score >= thr_before);
    heap_go    = enabled && comp_now && (!full || (actual_score > root));
    skip_next  = skip;
    if (enabled && !comp_now && skip != {SCORE_W{1'b1}}) begin
      skip_next = skip + SCORE_W'(1);
    end
    cmd.op    = full ? OP_REPLACE : OP_APPEND;
    cmd.count = fill_eff;
    cmd.value = actual_score;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_enable <= 1'b1;
      top_k         <= FILL_W'(10);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FILTER_ENABLE: filter_enable <= cfg_data[0];
        REG_TOP_K:         top_k         <= cfg_data[FILL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Held count, skip counter and control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
      fill  <= '0;
      skip  <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (accept) begin
        fill <= fill_eff + FILL_W'(heap_go && !full);
        skip <= skip_next;
        if (heap_go) begin
          state <= T_WAIT;
        end else begin
          done <= 1'b1;
        end
      end else if (state == T_WAIT && hu_done) begin
        state <= T_IDLE;
        done  <= 1'b1;
      end
    end
  end

  // Result beat registers.
  always_ff @(posedge clk) begin
    if (accept && !heap_go) begin
      competitive       <= comp_now;
      inserted          <= 1'b0;
      current_threshold <= enabled ? thr_before : '0;
      kept_count        <= fill_eff;
      skipped_total     <= skip_next;
    end else if (state == T_WAIT && hu_done) begin
      competitive       <= 1'b1;
      inserted          <= 1'b1;
      current_threshold <= (fill >= k_eff) ? root : '0;
      kept_count        <= fill;
      skipped_total     <= skip;
    end
  end

  tsf_heap_unit #(
    .HEAP_DEPTH(HEAP_DEPTH)
  ) u_heap (
    .clk  (clk),
    .rst  (rst),
    .go   (accept && heap_go),
    .cmd  (cmd),
    .done (hu_done),
    .root (root)
  );

  a_fill_cap: assert property (@(posedge clk) disable iff (rst)
    fill <= KCAP)
    else $error("held count exceeds the heap size");

  a_wait_fill: assert property (@(posedge clk) disable iff (rst)
    busy |-> fill != '0)
    else $error("heap insertion in progress with an empty heap");

  a_skip_mono: assert property (@(posedge clk)
    $past(!rst) |-> skip >= $past(skip))
    else $error("skip counter went backwards");

endmodule

`default_nettype wire

@@ rtl/core/tsf_heap_unit.sv @@
// Min-heap store with a small sequencer that sifts one level per cycle.
`default_nettype none

module tsf_heap_unit import tsf_pkg::*; #(
  parameter int HEAP_DEPTH = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               go,
  input  wire heap_cmd_t          cmd,
  output logic                    done,
  output logic [SCORE_W-1:0]      root
);

  localparam int IDX_W = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int CW    = (IDX_W + 2 > FILL_W) ? IDX_W + 2 : FILL_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_UP   = 2'd1;
  localparam logic [1:0] S_DN   = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]         state, state_next;
  logic [IDX_W-1:0]   pos, pos_next;
  logic [IDX_W-1:0]   par, par_next;
  logic [SCORE_W-1:0] val, val_next;
  logic [CW-1:0]      size, size_next;
  logic               done_next;

  // Heap storage: one write port, two registered read ports.
  logic [SCORE_W-1:0] heap_mem [HEAP_DEPTH];
  logic [SCORE_W-1:0] rd_a_data, rd_b_data;
  logic [IDX_W-1:0]   rd_a_addr, rd_b_addr;
  logic               we;
  logic [IDX_W-1:0]   waddr;
  logic [SCORE_W-1:0] wdata;

  logic [CW-1:0]      cmd_cnt;
  logic [IDX_W-1:0]   cmd_par;
  logic [IDX_W-1:0]   up_par;
  logic [CW-1:0]      c1, c2, mc, nc1, nc2;
  logic               pick_b;
  logic [SCORE_W-1:0] mval;

  // Index arithmetic for the parent and the two children.
  always_comb begin
    cmd_cnt = CW'(cmd.count);
    cmd_par = (cmd_cnt[IDX_W-1:0] - IDX_W'(1)) >> 1;
    up_par  = (par - IDX_W'(1)) >> 1;
    c1      = (CW'(pos) << 1) + CW'(1);
    c2      = c1 + CW'(1);
    // One compare picks the smaller child; a tie picks the first child.
    pick_b  = (c2 < size) && (rd_b_data < rd_a_data);
    mc      = pick_b ? c2 : c1;
    mval    = pick_b ? rd_b_data : rd_a_data;
    nc1     = (mc << 1) + CW'(1);
    nc2     = nc1 + CW'(1);
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    pos_next   = pos;
    par_next   = par;
    val_next   = val;
    size_next  = size;
    done_next  = 1'b0;
    we         = 1'b0;
    waddr      = pos;
    wdata      = val;
    rd_a_addr  = par;
    rd_b_addr  = '0;
    case (state)
      S_IDLE: begin
        if (go) begin
          val_next = cmd.value;
          if (cmd.op == OP_APPEND) begin
            pos_next = cmd_cnt[IDX_W-1:0];
            if (cmd_cnt == '0) begin
              we        = 1'b1;
              waddr     = '0;
              wdata     = cmd.value;
              done_next = 1'b1;
            end else begin
              par_next   = cmd_par;
              rd_a_addr  = cmd_par;
              state_next = S_UP;
            end
          end else begin
            pos_next  = '0;
            size_next = cmd_cnt;
            if (cmd_cnt < CW'(2)) begin
              we        = 1'b1;
              waddr     = '0;
              wdata     = cmd.value;
              done_next = 1'b1;
            end else begin
              rd_a_addr  = IDX_W'(1);
              rd_b_addr  = IDX_W'(2);
              state_next = S_DN;
            end
          end
        end
      end
      S_UP: begin
        // Move the parent down while it is larger than the new score.
        we = 1'b1;
        if (rd_a_data > val) begin
          wdata    = rd_a_data;
          pos_next = par;
          if (par == '0) begin
            state_next = S_FIN;
          end else begin
            par_next  = up_par;
            rd_a_addr = up_par;
          end
        end else begin
          done_next  = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_DN: begin
        // Move the smaller child up while it is below the new root score.
        we = 1'b1;
        if (mval < val) begin
          wdata    = mval;
          pos_next = mc[IDX_W-1:0];
          if (nc1 < size) begin
            rd_a_addr = nc1[IDX_W-1:0];
            rd_b_addr = nc2[IDX_W-1:0];
          end else begin
            state_next = S_FIN;
          end
        end else begin
          done_next  = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_FIN: begin
        we         = 1'b1;
        done_next  = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    pos  <= pos_next;
    par  <= par_next;
    val  <= val_next;
    size <= size_next;
  end

  // Copy of the top entry so the threshold needs no read.
  always_ff @(posedge clk) begin
    if (we && waddr == '0) begin
      root <= wdata;
    end
  end

  // Heap memory.
  always_ff @(posedge clk) begin
    if (we) begin
      heap_mem[waddr] <= wdata;
    end
    rd_a_data <= heap_mem[rd_a_addr];
    rd_b_data <= heap_mem[rd_b_addr];
  end

  a_go_idle: assert property (@(posedge clk) disable iff (rst)
    go |-> state == S_IDLE)
    else $error("heap operation started while the unit was busy");

  a_up_order: assert property (@(posedge clk) disable iff (rst)
    state == S_UP |-> par < pos)
    else $error("sift-up parent is not above the hole");

  a_dn_inside: assert property (@(posedge clk) disable iff (rst)
    state == S_DN |-> c1 < size)
    else $error("sift-down stepped past the held entries");

  a_done_write: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(we))
    else $error("heap operation finished without a final write");

endmodule

`default_nettype wire
